// ===== rtl/bffa_pkg.sv =====
// Shared constants, request/result types and map access struct for the bitmap allocator.
package bffa_pkg;

  localparam int MAP_BITS  = 8192;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
  localparam int WIDX_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ENT_W     = WIDX_W + BIT_W;
  localparam int NUM_W     = 14;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam logic REG_ENTRY_TOTAL = 1'b0;
  localparam logic [NUM_W-1:0] TOTAL_RESET = NUM_W'(MAP_BITS);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                 command;
    logic [NUM_W-1:0]     entry_number;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_data;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [NUM_W-1:0] granted_number;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [WIDX_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WIDX_W-1:0]    raddr;
  } map_req_t;

endpackage

// ===== rtl/bffa_map_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bffa_map_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bffa_find.sv =====
// Lowest-clear-bit finder for one bitmap word, limited to the usable entries.
module bffa_find
  import bffa_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic                 last_word,
  input  logic [BIT_W-1:0]     last_bit,
  output logic                 found,
  output logic [BIT_W-1:0]     bit_idx
);

  logic [WORD_BITS-1:0] limit;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] lowest;

  // In the last word only bits up to last_bit may be handed out.
  assign limit     = last_word ? ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit))
                               : {WORD_BITS{1'b1}};
  assign free_bits = ~word & limit;
  // Isolate the lowest set bit, then encode the one-hot position.
  assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));
  assign found     = |free_bits;

  always_comb begin
    bit_idx = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> k) & 1) == 1) begin
          bit_idx[k] = bit_idx[k] | lowest[i];
        end
      end
    end
  end

endmodule

// ===== rtl/bffa_ctrl.sv =====
// Command sequencer: word scan, read-modify-write of the map and result register.
module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [NUM_W-1:0]     entry_total,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  output map_req_t             map_req,
  input  logic [WORD_BITS-1:0] map_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SET,
    S_CLR,
    S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [WIDX_W-1:0]    wrd_r, wrd_nxt;
  logic [WIDX_W-1:0]    last_w_r, last_w_nxt;
  logic [BIT_W-1:0]     last_b_r, last_b_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  out_item_t            res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [NUM_W-1:0]     total;
  logic [ENT_W-1:0]     total_m1;
  logic [ENT_W-1:0]     ent;
  logic                 found;
  logic [BIT_W-1:0]     found_bit;

  assign total    = (entry_total > TOTAL_RESET) ? TOTAL_RESET : entry_total;
  assign total_m1 = ENT_W'(total - NUM_W'(1));
  assign ent      = ENT_W'(in_data.entry_number - NUM_W'(1));

  bffa_find u_find (
    .word      (map_rdata),
    .last_word (wrd_r == last_w_r),
    .last_bit  (last_b_r),
    .found     (found),
    .bit_idx   (found_bit)
  );

  always_comb begin
    state_nxt     = state_r;
    wrd_nxt       = wrd_r;
    last_w_nxt    = last_w_r;
    last_b_nxt    = last_b_r;
    bit_nxt       = bit_r;
    word_nxt      = word_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    map_req.we    = 1'b0;
    map_req.waddr = wrd_r;
    map_req.wdata = word_r | (WORD_BITS'(1) << bit_r);
    map_req.raddr = wrd_r;

    // Drop the result once the sink takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RESP;
          res_nxt   = '{status: ST_OK, granted_number: '0};
          case (in_data.command)
            CMD_ALLOC: begin
              if (total == '0) begin
                res_nxt.status = ST_NONE_FREE;
              end else begin
                map_req.raddr = '0;
                wrd_nxt       = '0;
                last_w_nxt    = total_m1[ENT_W-1:BIT_W];
                last_b_nxt    = total_m1[BIT_W-1:0];
                state_nxt     = S_SCAN;
              end
            end
            CMD_FREE: begin
              if (in_data.entry_number == '0 || in_data.entry_number > total) begin
                res_nxt.status = ST_RANGE;
              end else begin
                map_req.raddr = ent[ENT_W-1:BIT_W];
                wrd_nxt       = ent[ENT_W-1:BIT_W];
                bit_nxt       = ent[BIT_W-1:0];
                state_nxt     = S_CLR;
              end
            end
            CMD_LOAD: begin
              map_req.we    = 1'b1;
              map_req.waddr = in_data.word_index;
              map_req.wdata = in_data.word_data;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // Check the word read last cycle, fetch the next one.
        if (found) begin
          word_nxt  = map_rdata;
          bit_nxt   = found_bit;
          state_nxt = S_SET;
        end else if (wrd_r == last_w_r) begin
          res_nxt   = '{status: ST_NONE_FREE, granted_number: '0};
          state_nxt = S_RESP;
        end else begin
          wrd_nxt       = wrd_r + WIDX_W'(1);
          map_req.raddr = wrd_r + WIDX_W'(1);
        end
      end
      S_SET: begin
        map_req.we = 1'b1;
        res_nxt    = '{status: ST_OK,
                       granted_number: NUM_W'({wrd_r, bit_r}) + NUM_W'(1)};
        state_nxt  = S_RESP;
      end
      S_CLR: begin
        map_req.we    = 1'b1;
        map_req.wdata = map_rdata & ~(WORD_BITS'(1) << bit_r);
        res_nxt       = '{status: ST_OK, granted_number: '0};
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wrd_r      <= wrd_nxt;
    last_w_r   <= last_w_nxt;
    last_b_r   <= last_b_nxt;
    bit_r      <= bit_nxt;
    word_r     <= word_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bitmap_first_fit_allocator.sv =====
// Top level of the bitmap first-fit allocator: config register, map RAM and sequencer.
//
// The allocator keeps a used/free bitmap of 8192 entries as 128 words of 64 bits
// in a synchronous RAM. The map has no reset and no clearing pass: software must
// load every word (load request, one word per request) before allocate or free
// touches it. One request is worked on at a time; the finished result sits in an
// output register, so the next request is taken while that result waits. Steps per
// request: load and no-op go straight to the result; free reads the word, then
// writes it back modified, then gives the result; an out-of-range free or an
// allocate with a zero total goes straight to the result; allocate scans the map
// word by word from word 0, at most 128 words, then writes the found word and gives
// the result; an allocate that finds no free entry skips the write. The scan rate is
// set by the single RAM read port: one word per cycle, checked by a 64-bit
// lowest-free-bit finder, followed by one write of the found word. The usable
// total is min(entry_total, 8192); entry_total sits at byte address 0 of the APB
// port and resets to 8192. Change it only while no request is outstanding.
module bitmap_first_fit_allocator
  import bffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [NUM_W-1:0]     entry_total_r;
  logic [NUM_W-1:0]     entry_total_nxt;
  logic                 reg_sel;
  map_req_t             map_req;
  logic [WORD_BITS-1:0] map_rdata;

  // Register index is the word address.
  assign reg_sel = paddr[ADDR_W-1];
  assign pready  = 1'b1;

  always_comb begin
    entry_total_nxt = entry_total_r;
    if (psel && penable && pwrite && reg_sel == REG_ENTRY_TOTAL) begin
      entry_total_nxt = pwdata[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_total_r <= TOTAL_RESET;
    end else begin
      entry_total_r <= entry_total_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ENTRY_TOTAL: prdata = DATA_W'(entry_total_r);
      default:         prdata = '0;
    endcase
  end

  bffa_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_req.we),
    .waddr (map_req.waddr),
    .wdata (map_req.wdata),
    .raddr (map_req.raddr),
    .rdata (map_rdata)
  );

  bffa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_total (entry_total_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .map_req     (map_req),
    .map_rdata   (map_rdata)
  );

  // One request at a time: an accepted request blocks the input next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in progress");

  // Only a successful allocate carries a nonzero number.
  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> out_data.granted_number == '0)
    else $error("nonzero number with failing status");

  // A granted number stays within the usable total.
  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.granted_number != '0) |->
      (out_data.granted_number <= entry_total_r &&
       out_data.granted_number <= TOTAL_RESET))
    else $error("granted number beyond usable total");

endmodule
